FILE: src/circle_pair_contact_core_assert.svh
// Assertion macros for the circle pair contact RTL.
// Uses clk and rst_n from the including module's scope.
`ifndef CIRCLE_PAIR_CONTACT_CORE_ASSERT_SVH
`define CIRCLE_PAIR_CONTACT_CORE_ASSERT_SVH

// same-cycle implication
`define CCP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ccp_pkg.sv
// Package for the circle pair contact core: widths, constants and types.
// No dependencies; used by every module of the block.
package ccp_pkg;

  localparam int IN_W     = 240;
  localparam int OUT_W    = 104;
  localparam int F_W      = 24;
  localparam int D_W      = 26;
  localparam int R_W      = 24;
  localparam int SQ_W     = 51;
  localparam int RT_IN_W  = 62;
  localparam int RT_W     = 31;
  localparam int NUM_W    = 48;
  localparam int Q_W      = 17;
  localparam int N_W      = 16;
  localparam int P_W      = 41;
  localparam int QD       = 4;
  localparam int QA_W     = 2;
  localparam int QC_W     = 3;

  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);
  localparam logic [25:0]    FIX_MAX = 26'd8388607;

  typedef struct packed {
    logic                    hit;
    logic                    zero;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic [R_W-1:0]          rsum;
    logic [NUM_W-1:0]        d2;
  } ccp_item_t;

  typedef struct packed {
    logic                    hit;
    logic                    zero;
    logic                    neg_x;
    logic                    neg_y;
    logic [D_W-1:0]          mx;
    logic [D_W-1:0]          my;
    logic [R_W-1:0]          rsum;
  } ccp_side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ccp_q_stat_t;

  function automatic logic signed [D_W-1:0] sx(input logic [F_W-1:0] v);
    sx = {{(D_W-F_W){v[F_W-1]}}, v};
  endfunction

endpackage

FILE: src/ccp_front.sv
// Front end: accepts pair words, forms centre difference, squares, hit class.
// Depends on ccp_pkg; feeds ccp_fifo.
module ccp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ccp_pkg::IN_W-1:0] in_tdata,
  input  ccp_pkg::ccp_q_stat_t   q_stat,
  output logic                   q_push,
  output ccp_pkg::ccp_item_t     q_item
);
  import ccp_pkg::*;

  logic                  en;
  logic                  a_vld_r, b_vld_r, c_vld_r;
  logic signed [D_W-1:0] dx_nxt, dy_nxt, dx_a_r, dy_a_r, dx_b_r, dy_b_r;
  logic [R_W-1:0]        rsum_nxt, rsum_a_r, rsum_b_r;
  logic signed [2*D_W-1:0] px, py;
  logic [SQ_W-1:0]       sqx_b_r, sqy_b_r;
  logic [2*R_W-1:0]      r2_b_r;
  logic [SQ_W:0]         d2_nxt;
  ccp_item_t             item_nxt, item_r;

  assign en        = !c_vld_r || !q_stat.full;
  assign in_tready = en;
  assign q_push    = c_vld_r && !q_stat.full;
  assign q_item    = item_r;

  always_comb begin
    dx_nxt   = sx(in_tdata[23:0]) + sx(in_tdata[71:48])
             - sx(in_tdata[142:119]) - sx(in_tdata[190:167]);
    dy_nxt   = sx(in_tdata[47:24]) + sx(in_tdata[95:72])
             - sx(in_tdata[166:143]) - sx(in_tdata[214:191]);
    rsum_nxt = {1'b0, in_tdata[118:96]} + {1'b0, in_tdata[237:215]};
  end

  assign px = dx_a_r * dx_a_r;
  assign py = dy_a_r * dy_a_r;

  always_comb begin
    d2_nxt        = {1'b0, sqx_b_r} + {1'b0, sqy_b_r};
    item_nxt.hit  = d2_nxt < {{(SQ_W+1-2*R_W){1'b0}}, r2_b_r};
    item_nxt.zero = d2_nxt == '0;
    item_nxt.dx   = dx_b_r;
    item_nxt.dy   = dy_b_r;
    item_nxt.rsum = rsum_b_r;
    item_nxt.d2   = d2_nxt[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a_r   <= dx_nxt;
      dy_a_r   <= dy_nxt;
      rsum_a_r <= rsum_nxt;
      sqx_b_r  <= px[SQ_W-1:0];
      sqy_b_r  <= py[SQ_W-1:0];
      r2_b_r   <= rsum_a_r * rsum_a_r;
      dx_b_r   <= dx_a_r;
      dy_b_r   <= dy_a_r;
      rsum_b_r <= rsum_a_r;
      item_r   <= item_nxt;
    end
  end

endmodule

FILE: src/ccp_fifo.sv
// Short queue between front and back ends.
// Depends on ccp_pkg and the assertion macro header.
module ccp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ccp_pkg::ccp_item_t   wr_item,
  input  logic                 pop,
  output ccp_pkg::ccp_item_t   rd_item,
  output ccp_pkg::ccp_q_stat_t stat
);
  import ccp_pkg::*;
  `include "circle_pair_contact_core_assert.svh"

  ccp_item_t       mem_r [0:QD-1];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;

  assign stat.full  = cnt_r == QC_W'(QD);
  assign stat.empty = cnt_r == '0;
  assign rd_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QA_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QA_W'(1);
      if (push && !pop) cnt_r <= cnt_r + QC_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

  `CCP_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= QC_W'(QD), "queue count beyond depth")
  `CCP_ASSERT_SAME(a_ptr_gap, 1'b1, (wr_ptr_r - rd_ptr_r) == cnt_r[QA_W-1:0], "pointer gap")
  `CCP_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + QC_W'(1), "count not raised")

endmodule

FILE: src/ccp_back.sv
// Back end: pipelined root, normal division, depth and correction, output register.
// Depends on ccp_pkg; drains ccp_fifo.
module ccp_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ccp_pkg::ccp_item_t       rd_item,
  input  ccp_pkg::ccp_q_stat_t     q_stat,
  output logic                     q_pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [ccp_pkg::OUT_W-1:0] out_tdata,
  output logic                     out_tuser
);
  import ccp_pkg::*;

  logic en;

  logic               rt_vld_r  [0:RT_W];
  logic [RT_IN_W-1:0] rt_rem_r  [0:RT_W];
  logic [RT_W-1:0]    rt_root_r [0:RT_W];
  ccp_side_t          rt_side_r [0:RT_W];
  ccp_side_t          side_nxt;

  logic               dv_vld_r  [0:Q_W];
  logic [NUM_W-1:0]   dv_rx_r   [0:Q_W];
  logic [NUM_W-1:0]   dv_ry_r   [0:Q_W];
  logic [Q_W-1:0]     dv_qx_r   [0:Q_W];
  logic [Q_W-1:0]     dv_qy_r   [0:Q_W];
  logic [RT_W-1:0]    dv_s_r    [0:Q_W];
  ccp_side_t          dv_side_r [0:Q_W];

  logic                  f1_vld_r, f1_hit_r;
  logic signed [N_W-1:0] f1_nx_r, f1_ny_r, nx_nxt, ny_nxt;
  logic [R_W-1:0]        f1_depth_r, depth_nxt, dist_rnd;
  logic [N_W-1:0]        magx, magy;
  ccp_side_t             fs;
  logic [RT_W-1:0]       fsr;

  logic                  f2_vld_r, f2_hit_r;
  logic signed [N_W-1:0] f2_nx_r, f2_ny_r;
  logic [R_W-1:0]        f2_depth_r;
  logic signed [P_W-1:0] f2_px_r, f2_py_r;

  logic [P_W-1:0]        pmx, pmy;
  logic [P_W-1:0]        rqx, rqy;
  logic [R_W-1:0]        fx, fy;

  logic                  out_vld_r, out_hit_r;
  logic [OUT_W-1:0]      out_data_r;

  assign en         = !out_vld_r || out_tready;
  assign q_pop      = en && !q_stat.empty;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  always_comb begin
    side_nxt.hit   = rd_item.hit;
    side_nxt.zero  = rd_item.zero;
    side_nxt.neg_x = rd_item.dx[D_W-1];
    side_nxt.neg_y = rd_item.dy[D_W-1];
    side_nxt.mx    = rd_item.dx[D_W-1] ? D_W'(-rd_item.dx) : D_W'(rd_item.dx);
    side_nxt.my    = rd_item.dy[D_W-1] ? D_W'(-rd_item.dy) : D_W'(rd_item.dy);
    side_nxt.rsum  = rd_item.rsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rt_vld_r[0] <= 1'b0;
    else if (en) rt_vld_r[0] <= !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem_r[0]  <= (rd_item.hit && !rd_item.zero) ? {rd_item.d2, 14'd0} : '0;
      rt_root_r[0] <= '0;
      rt_side_r[0] <= side_nxt;
    end
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_rt
    localparam int B = RT_W - 1 - k;
    logic [RT_IN_W:0] t;
    logic             ge;
    always_comb begin
      t  = ({{(RT_IN_W+1-RT_W){1'b0}}, rt_root_r[k]} << (B + 1))
         | ((RT_IN_W+1)'(1) << (2 * B));
      ge = {1'b0, rt_rem_r[k]} >= t;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) rt_vld_r[k+1] <= 1'b0;
      else if (en) rt_vld_r[k+1] <= rt_vld_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem_r[k+1]  <= ge ? rt_rem_r[k] - t[RT_IN_W-1:0] : rt_rem_r[k];
        rt_root_r[k+1] <= rt_root_r[k] | (RT_W'(ge) << B);
        rt_side_r[k+1] <= rt_side_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (en) dv_vld_r[0] <= rt_vld_r[RT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rx_r[0]   <= {1'b0, rt_side_r[RT_W].mx, 21'd0}
                    + {{(NUM_W-RT_W+1){1'b0}}, rt_root_r[RT_W][RT_W-1:1]};
      dv_ry_r[0]   <= {1'b0, rt_side_r[RT_W].my, 21'd0}
                    + {{(NUM_W-RT_W+1){1'b0}}, rt_root_r[RT_W][RT_W-1:1]};
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
      dv_s_r[0]    <= rt_root_r[RT_W];
      dv_side_r[0] <= rt_side_r[RT_W];
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_dv
    localparam int K = Q_W - 1 - j;
    logic [NUM_W-1:0] den;
    logic             gex, gey;
    always_comb begin
      den = {{(NUM_W-RT_W){1'b0}}, dv_s_r[j]} << K;
      gex = dv_rx_r[j] >= den;
      gey = dv_ry_r[j] >= den;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[j+1] <= 1'b0;
      else if (en) dv_vld_r[j+1] <= dv_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rx_r[j+1]   <= gex ? dv_rx_r[j] - den : dv_rx_r[j];
        dv_ry_r[j+1]   <= gey ? dv_ry_r[j] - den : dv_ry_r[j];
        dv_qx_r[j+1]   <= dv_qx_r[j] | (Q_W'(gex) << K);
        dv_qy_r[j+1]   <= dv_qy_r[j] | (Q_W'(gey) << K);
        dv_s_r[j+1]    <= dv_s_r[j];
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end
  end

  always_comb begin
    fs       = dv_side_r[Q_W];
    fsr      = dv_s_r[Q_W];
    magx     = (dv_qx_r[Q_W] > ONE_Q14) ? N_W'(ONE_Q14) : dv_qx_r[Q_W][N_W-1:0];
    magy     = (dv_qy_r[Q_W] > ONE_Q14) ? N_W'(ONE_Q14) : dv_qy_r[Q_W][N_W-1:0];
    dist_rnd = fsr[RT_W-1:7] + R_W'(fsr[6]);
    priority if (!fs.hit) begin
      nx_nxt    = '0;
      ny_nxt    = '0;
      depth_nxt = '0;
    end else if (fs.zero) begin
      nx_nxt    = -$signed(N_W'(ONE_Q14));
      ny_nxt    = '0;
      depth_nxt = fs.rsum;
    end else begin
      nx_nxt    = fs.neg_x ? $signed(magx) : -$signed(magx);
      ny_nxt    = fs.neg_y ? $signed(magy) : -$signed(magy);
      depth_nxt = fs.rsum - dist_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      f2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r  <= dv_vld_r[Q_W];
      f2_vld_r  <= f1_vld_r;
      out_vld_r <= f2_vld_r;
    end
  end

  always_comb begin
    pmx = f2_px_r[P_W-1] ? P_W'(-f2_px_r) : P_W'(f2_px_r);
    pmy = f2_py_r[P_W-1] ? P_W'(-f2_py_r) : P_W'(f2_py_r);
    rqx = (pmx + P_W'(16384)) >> 15;
    rqy = (pmy + P_W'(16384)) >> 15;
    fx  = (rqx[25:0] > FIX_MAX) ? FIX_MAX[R_W-1:0] : rqx[R_W-1:0];
    fy  = (rqy[25:0] > FIX_MAX) ? FIX_MAX[R_W-1:0] : rqy[R_W-1:0];
    if (f2_px_r[P_W-1]) fx = -fx;
    if (f2_py_r[P_W-1]) fy = -fy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_hit_r   <= fs.hit;
      f1_nx_r    <= nx_nxt;
      f1_ny_r    <= ny_nxt;
      f1_depth_r <= depth_nxt;
      f2_hit_r   <= f1_hit_r;
      f2_nx_r    <= f1_nx_r;
      f2_ny_r    <= f1_ny_r;
      f2_depth_r <= f1_depth_r;
      f2_px_r    <= $signed({1'b0, f1_depth_r}) * f1_nx_r;
      f2_py_r    <= $signed({1'b0, f1_depth_r}) * f1_ny_r;
      out_hit_r  <= f2_hit_r;
      out_data_r <= {fy, fx, f2_depth_r, f2_ny_r, f2_nx_r};
    end
  end

endmodule

FILE: src/circle_pair_contact_core.sv
// Circle pair contact core, one pair of circles per word in, one contact word out.
// Input in_tdata (lowest first): pos1_x, pos1_y, off1_x, off1_y, radius1,
//   pos2_x, pos2_y, off2_x, off2_y, radius2, zero pad to 240 bits.
// Output out_tdata (lowest first): normal_x, normal_y, depth, fix_half_x,
//   fix_half_y; out_tuser carries hit. Misses give all-zero data.
// Throughput: one pair per cycle sustained while out_tready stays high.
// Path from input acceptance to out_tvalid: front end, queue, the 31-stage
//   root pipeline, the 17-stage normal divider and the output registers.
// A three-stage front end feeds a four-word queue; the back end pipeline
// advances only while the output register is empty or being taken, so a
// stalled receiver first fills the queue, then drops in_tready.
// Reset (rst_n low, synchronous) empties every stage and the queue;
// in_tready is high once reset has cleared the front end's last stage.
// Depends on ccp_pkg, ccp_front, ccp_fifo, ccp_back.
module circle_pair_contact_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ccp_pkg::IN_W-1:0]  in_tdata,   // pos1_x..radius2, see above
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ccp_pkg::OUT_W-1:0] out_tdata,  // normal_x, normal_y, depth, fix_x, fix_y
  output logic                      out_tuser   // hit
);
  import ccp_pkg::*;

  ccp_q_stat_t q_stat;
  ccp_item_t   wr_item, rd_item;
  logic        q_push, q_pop;

  ccp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (wr_item)
  );

  ccp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  ccp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_item    (rd_item),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
